FILE: hdl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared constants for the IMU frame parser and angle extractor.
// ----------------------------------------------------------------------------
package imufp_pkg;

  localparam int unsigned PosW = 9;

  localparam logic [7:0] PreambleByte     = 8'hFA;
  localparam logic [7:0] DefaultMessageId = 8'h36;

  // Frame positions: hunting, bus byte, message id, length, then payload.
  localparam logic [PosW-1:0] PosHunt    = 9'd0;
  localparam logic [PosW-1:0] PosBus     = 9'd1;
  localparam logic [PosW-1:0] PosId      = 9'd2;
  localparam logic [PosW-1:0] PosLength  = 9'd3;
  localparam logic [PosW-1:0] PosPayload = 9'd4;

  // Payload indices carrying the three angle words.
  localparam logic [PosW-1:0] AngleFirst = 9'd3;
  localparam logic [PosW-1:0] AngleLast  = 9'd14;
  localparam logic [7:0]      AngleMinLength = 8'd15;

endpackage

FILE: hdl/imufp_byte_if.sv
// ----------------------------------------------------------------------------
// imufp_byte_if
// Received byte channel: valid/ready with one serial byte.
// ----------------------------------------------------------------------------
interface imufp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/imufp_cfg_if.sv
// ----------------------------------------------------------------------------
// imufp_cfg_if
// Configuration write channel: expected message id.
// ----------------------------------------------------------------------------
interface imufp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_message_id;

  modport source (output valid, output expected_message_id, input ready);
  modport sink   (input valid, input expected_message_id, output ready);
endinterface

FILE: hdl/imufp_result_if.sv
// ----------------------------------------------------------------------------
// imufp_result_if
// Frame result channel: flags, length and the three angle words.
// ----------------------------------------------------------------------------
interface imufp_result_if;
  logic        valid;
  logic        ready;
  logic        frame_accepted;
  logic        id_matched;
  logic        checksum_good;
  logic [7:0]  payload_length;
  logic        angles_present;
  logic [31:0] pitch_bits;
  logic [31:0] roll_bits;
  logic [31:0] yaw_bits;

  modport source (
    output valid, output frame_accepted, output id_matched, output checksum_good,
    output payload_length, output angles_present, output pitch_bits,
    output roll_bits, output yaw_bits, input ready
  );
  modport sink (
    input valid, input frame_accepted, input id_matched, input checksum_good,
    input payload_length, input angles_present, input pitch_bits,
    input roll_bits, input yaw_bits, output ready
  );
endinterface

FILE: hdl/imu_frame_parser_angle_extract_core.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_angle_extract_core
// Byte-wise binary message parser: preamble hunt, id check, running checksum,
// big-endian capture of pitch, roll and yaw words, one result per frame.
//
//   channel  dir  modport  payload
//   rx_i     in   sink     rx_byte
//   cfg_i    in   sink     expected_message_id
//   res_o    out  source   flags, payload_length, pitch/roll/yaw bits
//
// One byte per cycle. A result appears in the output register the cycle
// after the checksum byte transfer. Bytes that complete no frame are taken
// even while a result waits; the checksum byte waits only for a free output
// register. Reset returns to preamble hunting with id 0x36.
// ----------------------------------------------------------------------------
module imu_frame_parser_angle_extract_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  imufp_byte_if.sink           rx_i,
  imufp_cfg_if.sink            cfg_i,
  imufp_result_if.source       res_o
);
  import imufp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic            match_q, match_d;
  logic [7:0]      len_q, len_d;
  logic [31:0]     pitch_q, pitch_d;
  logic [31:0]     roll_q, roll_d;
  logic [31:0]     yaw_q, yaw_d;
  logic [7:0]      exp_id_q;

  logic            res_valid_q;
  logic            res_accepted_q, res_match_q, res_good_q, res_present_q;
  logic [7:0]      res_len_q;
  logic [31:0]     res_pitch_q, res_roll_q, res_yaw_q;

  logic            at_payload, at_checksum, rx_xfer, emit, present, good;
  logic [PosW-1:0] idx, k;
  logic [31:0]     lane_mask, lane_data;

  assign at_payload  = (pos_q >= PosPayload);
  assign idx         = pos_q - PosPayload;
  assign at_checksum = at_payload && (idx >= {1'b0, len_q});

  assign rx_i.ready  = !at_checksum || !res_valid_q || res_o.ready;
  assign rx_xfer     = rx_i.valid && rx_i.ready;
  assign emit        = rx_xfer && at_checksum;

  assign sum_d   = sum_q + rx_i.rx_byte;
  assign good    = (sum_d == 8'd0);
  assign present = (len_q >= AngleMinLength);

  assign k = idx - AngleFirst;

  always_comb begin
    case (k[1:0])
      2'd0:    lane_mask = 32'hFF00_0000;
      2'd1:    lane_mask = 32'h00FF_0000;
      2'd2:    lane_mask = 32'h0000_FF00;
      default: lane_mask = 32'h0000_00FF;
    endcase
    lane_data = {4{rx_i.rx_byte}} & lane_mask;
  end

  always_comb begin
    pos_d   = pos_q;
    match_d = match_q;
    len_d   = len_q;
    pitch_d = pitch_q;
    roll_d  = roll_q;
    yaw_d   = yaw_q;
    case (pos_q)
      PosHunt: begin
        if (rx_i.rx_byte == PreambleByte) begin
          pos_d   = PosBus;
          match_d = 1'b0;
          len_d   = 8'd0;
          pitch_d = '0;
          roll_d  = '0;
          yaw_d   = '0;
        end
      end
      PosBus:    pos_d = PosId;
      PosId: begin
        match_d = (rx_i.rx_byte == exp_id_q);
        pos_d   = PosLength;
      end
      PosLength: begin
        len_d = rx_i.rx_byte;
        pos_d = PosPayload;
      end
      default: begin
        if (at_checksum) begin
          pos_d = PosHunt;
        end else begin
          pos_d = pos_q + 1'b1;
          if (idx >= AngleFirst && idx <= AngleLast) begin
            case (k[3:2])
              2'd0:    pitch_d = (pitch_q & ~lane_mask) | lane_data;
              2'd1:    roll_d  = (roll_q  & ~lane_mask) | lane_data;
              default: yaw_d   = (yaw_q   & ~lane_mask) | lane_data;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      sum_q   <= 8'd0;
      match_q <= 1'b0;
      len_q   <= 8'd0;
      pitch_q <= '0;
      roll_q  <= '0;
      yaw_q   <= '0;
    end else if (rx_xfer) begin
      pos_q   <= pos_d;
      sum_q   <= (pos_q == PosHunt) ? 8'd0 : sum_d;
      match_q <= match_d;
      len_q   <= len_d;
      pitch_q <= pitch_d;
      roll_q  <= roll_d;
      yaw_q   <= yaw_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= DefaultMessageId;
    end else if (cfg_i.valid) begin
      exp_id_q <= cfg_i.expected_message_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_accepted_q <= match_q && good;
      res_match_q    <= match_q;
      res_good_q     <= good;
      res_len_q      <= len_q;
      res_present_q  <= present;
      res_pitch_q    <= present ? pitch_q : 32'd0;
      res_roll_q     <= present ? roll_q  : 32'd0;
      res_yaw_q      <= present ? yaw_q   : 32'd0;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.frame_accepted = res_accepted_q;
  assign res_o.id_matched     = res_match_q;
  assign res_o.checksum_good  = res_good_q;
  assign res_o.payload_length = res_len_q;
  assign res_o.angles_present = res_present_q;
  assign res_o.pitch_bits     = res_pitch_q;
  assign res_o.roll_bits      = res_roll_q;
  assign res_o.yaw_bits       = res_yaw_q;

endmodule

FILE: test/imu_frame_parser_angle_extract_core_tb.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_angle_extract_core_tb
// Self-checking bench for the IMU frame parser. A byte stream of directed
// frames, then random frames, noise and broken frames, is fed under random
// gaps on both channels. A frame tracker predicts each result, which is
// checked field by field. The expected id is rewritten between phases.
// ----------------------------------------------------------------------------
module imu_frame_parser_angle_extract_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imufp_pkg::*;

  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {FeedByte, FeedConfig, FeedDrain} feed_kind_e;

  typedef struct {
    feed_kind_e kind;
    logic [7:0] value;
  } feed_item_t;

  typedef struct packed {
    logic        frame_accepted;
    logic        id_matched;
    logic        checksum_good;
    logic [7:0]  payload_length;
    logic        angles_present;
    logic [31:0] pitch_bits;
    logic [31:0] roll_bits;
    logic [31:0] yaw_bits;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  imufp_byte_if   rx_if ();
  imufp_cfg_if    cfg_if ();
  imufp_result_if res_if ();

  imu_frame_parser_angle_extract_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #5ns clk_i = ~clk_i;

  feed_item_t    feed_q[$];
  frame_result_t frames_due_q[$];

  int unsigned fed_bytes;
  int unsigned bytes_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned settle_cnt;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit          first_hold_done;
  bit          second_hold_done;
  bit          rx_taken;
  bit          cfg_taken;

  // Frame tracker state
  logic [PosW-1:0] trk_pos;
  logic [7:0]      trk_sum;
  logic            trk_id_hit;
  logic [7:0]      trk_len;
  logic [31:0]     trk_pitch;
  logic [31:0]     trk_roll;
  logic [31:0]     trk_yaw;
  logic [7:0]      live_id;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic track_frame_byte(input logic [7:0] b);
    logic [PosW-1:0] idx;
    logic [3:0]      k;
    int unsigned     sh;
    frame_result_t   r;
    idx = trk_pos - PosPayload;
    if (trk_pos == PosHunt) begin
      if (b == PreambleByte) begin
        trk_sum    = '0;
        trk_id_hit = 1'b0;
        trk_len    = '0;
        trk_pitch  = '0;
        trk_roll   = '0;
        trk_yaw    = '0;
        trk_pos    = PosBus;
      end
    end else begin
      trk_sum = trk_sum + b;
      case (trk_pos)
        PosBus: begin
          trk_pos = PosId;
        end
        PosId: begin
          trk_id_hit = (b == live_id);
          trk_pos    = PosLength;
        end
        PosLength: begin
          trk_len = b;
          trk_pos = PosPayload;
        end
        default: begin
          if (idx < {1'b0, trk_len}) begin
            if (idx >= AngleFirst && idx <= AngleLast) begin
              k  = 4'(idx - AngleFirst);
              sh = 24 - 8 * k[1:0];
              case (k[3:2])
                2'd0:    trk_pitch[sh +: 8] = b;
                2'd1:    trk_roll[sh +: 8]  = b;
                default: trk_yaw[sh +: 8]   = b;
              endcase
            end
            trk_pos = trk_pos + 1'b1;
          end else begin
            r.id_matched     = trk_id_hit;
            r.checksum_good  = (trk_sum == 8'd0);
            r.frame_accepted = trk_id_hit && (trk_sum == 8'd0);
            r.payload_length = trk_len;
            r.angles_present = (trk_len >= AngleMinLength);
            r.pitch_bits     = r.angles_present ? trk_pitch : '0;
            r.roll_bits      = r.angles_present ? trk_roll  : '0;
            r.yaw_bits       = r.angles_present ? trk_yaw   : '0;
            frames_due_q.push_back(r);
            trk_pos = PosHunt;
          end
        end
      endcase
    end
  endtask

  // Stimulus builders
  task automatic push_byte(input logic [7:0] b);
    feed_item_t it;
    it.kind  = FeedByte;
    it.value = b;
    feed_q.push_back(it);
    fed_bytes++;
  endtask

  task automatic push_ctrl(input feed_kind_e kind, input logic [7:0] v);
    feed_item_t it;
    it.kind  = kind;
    it.value = v;
    feed_q.push_back(it);
  endtask

  task automatic push_frame(input logic [7:0] bus, input logic [7:0] id,
                            input logic [7:0] len, input bit good, input bit fa_rich);
    logic [7:0] sum;
    logic [7:0] p;
    sum = bus + id + len;
    push_byte(PreambleByte);
    push_byte(bus);
    push_byte(id);
    push_byte(len);
    for (int i = 0; i < len; i++) begin
      p = (fa_rich && $urandom_range(3) == 0) ? PreambleByte : 8'($urandom);
      sum = sum + p;
      push_byte(p);
    end
    p = 8'd0 - sum;
    if (!good) p = p + 8'($urandom_range(255, 1));
    push_byte(p);
  endtask

  task automatic random_segment(input int unsigned n, input logic [7:0] id_now);
    int unsigned stop;
    int unsigned r;
    int unsigned lr;
    logic [7:0]  len;
    logic [7:0]  id;
    stop = fed_bytes + n;
    while (fed_bytes < stop) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom));
      end else if (r < 15) begin
        // truncated frame; the tail swallows whatever follows
        push_byte(PreambleByte);
        repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
      end else begin
        lr = $urandom_range(99);
        if (lr < 45)      len = 8'($urandom_range(14));
        else if (lr < 85) len = 8'($urandom_range(24, 15));
        else if (lr < 97) len = 8'($urandom_range(64, 25));
        else              len = 8'($urandom_range(255, 65));
        id = ($urandom_range(99) < 75) ? id_now : 8'($urandom);
        push_frame(8'($urandom), id, len, $urandom_range(99) < 80,
                   $urandom_range(99) < 20);
      end
    end
  endtask

  // Byte and configuration driver
  always @(negedge clk_i) begin
    logic       nv;
    logic       ncv;
    logic [7:0] nb;
    logic [7:0] nid;
    feed_item_t head;
    nv  = 1'b0;
    ncv = 1'b0;
    nb  = rx_if.rx_byte;
    nid = cfg_if.expected_message_id;
    if (rx_taken) tx_gap = pick_gap(((bytes_taken >> 8) % 4) == 1);
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (rx_if.valid && !rx_taken) begin
      nv = 1'b1;
    end else if (cfg_if.valid && !cfg_taken) begin
      ncv = 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
    end else if (feed_q.size() > 0) begin
      head = feed_q[0];
      if (head.kind == FeedByte) begin
        nv = 1'b1;
        nb = head.value;
        void'(feed_q.pop_front());
      end else if (frames_due_q.size() == 0 && settle_cnt >= SettleCycles) begin
        if (head.kind == FeedConfig) begin
          ncv = 1'b1;
          nid = head.value;
        end
        void'(feed_q.pop_front());
      end
    end
    rx_taken  = 1'b0;
    cfg_taken = 1'b0;
    rx_if.valid                <= nv;
    rx_if.rx_byte              <= nb;
    cfg_if.valid               <= ncv;
    cfg_if.expected_message_id <= nid;
  end

  // Result receiver with random back-pressure and long hold-offs
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b0;
    if (results_seen >= 25 && !first_hold_done) begin
      first_hold_done = 1'b1;
      hold_left = 300;
    end else if (results_seen >= 70 && !second_hold_done) begin
      second_hold_done = 1'b1;
      hold_left = 200;
    end
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (rx_gap > 0) begin
      rx_gap--;
    end else begin
      if ($urandom_range(99) < 20) rx_gap = pick_gap(((results_seen >> 4) % 4) == 2);
      rdy = (rx_gap == 0);
      if (rx_gap > 0) rx_gap--;
    end
    res_if.ready <= rdy;
  end

  // Transfer monitor and checker
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        rx_taken = 1'b1;
        bytes_taken++;
        track_frame_byte(rx_if.rx_byte);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_taken = 1'b1;
        live_id   = cfg_if.expected_message_id;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (frames_due_q.size() == 0) begin
          report_mismatch("unexpected result, payload_length", res_if.payload_length, '0);
        end else begin
          want = frames_due_q.pop_front();
          compare_field("frame_accepted", res_if.frame_accepted, want.frame_accepted);
          compare_field("id_matched", res_if.id_matched, want.id_matched);
          compare_field("checksum_good", res_if.checksum_good, want.checksum_good);
          compare_field("payload_length", res_if.payload_length, want.payload_length);
          compare_field("angles_present", res_if.angles_present, want.angles_present);
          compare_field("pitch_bits", res_if.pitch_bits, want.pitch_bits);
          compare_field("roll_bits", res_if.roll_bits, want.roll_bits);
          compare_field("yaw_bits", res_if.yaw_bits, want.yaw_bits);
        end
      end
      if (frames_due_q.size() == 0 && !rx_if.valid && !cfg_if.valid) settle_cnt++;
      else settle_cnt = 0;
    end
  end

  initial begin
    rst_ni                     = 1'b0;
    rx_if.valid                = 1'b0;
    rx_if.rx_byte              = '0;
    cfg_if.valid               = 1'b0;
    cfg_if.expected_message_id = '0;
    res_if.ready               = 1'b0;
    trk_pos    = PosHunt;
    trk_sum    = '0;
    trk_id_hit = 1'b0;
    trk_len    = '0;
    trk_pitch  = '0;
    trk_roll   = '0;
    trk_yaw    = '0;
    live_id    = DefaultMessageId;

    // directed: noise, zero-length frame, full angle frame with preambles inside
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(8'hFF, DefaultMessageId, 8'd0, 1'b1, 1'b0);
    push_frame(8'h00, DefaultMessageId, AngleMinLength, 1'b1, 1'b1);

    push_ctrl(FeedConfig, 8'h00);
    random_segment(460, 8'h00);
    push_ctrl(FeedConfig, 8'hFF);
    random_segment(230, 8'hFF);
    push_ctrl(FeedDrain, '0);
    random_segment(230, 8'hFF);
    push_ctrl(FeedConfig, PreambleByte);
    random_segment(460, PreambleByte);
    push_ctrl(FeedConfig, DefaultMessageId);
    random_segment(460, DefaultMessageId);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || rx_if.valid || cfg_if.valid || frames_due_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("imu_frame_parser_angle_extract_core verification clean");
    end else begin
      $display("imu_frame_parser_angle_extract_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[%0t] timeout", $realtime);
    $display("imu_frame_parser_angle_extract_core verification failed");
    $finish;
  end

endmodule
